FILE: hdl/bdlp_pkg.sv
package bdlp_pkg;

	// Default build and register widths
	localparam int NUM_BUTTONS_DEF = 3;
	localparam int TICKS_W         = 16;
	localparam int ADDR_W          = 3;
	localparam int DATA_W          = 32;

	// Register reset values
	localparam logic [TICKS_W-1:0] LONG_TICKS_RST    = 16'd300;
	localparam logic               PRESSED_LEVEL_RST = 1'b0;

	// Register index, taken from paddr[2]
	localparam logic REG_LONG_TICKS    = 1'b0;
	localparam logic REG_PRESSED_LEVEL = 1'b1;

	// Request codes
	localparam logic [1:0] REQ_TICK       = 2'd0;
	localparam logic [1:0] REQ_TAKE_ONE   = 2'd1;
	localparam logic [1:0] REQ_TAKE_FIRST = 2'd2;

	// Summary codes
	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_PENDING = 2'd1;
	localparam logic [1:0] KIND_LONG    = 2'd2;

	typedef struct packed {
		logic [1:0] req_type;
		logic [2:0] pin_levels;
		logic [1:0] button_index;
	} req_item_t;

	typedef struct packed {
		logic [2:0] press_pending_mask;
		logic [2:0] long_press_mask;
		logic [2:0] held_mask;
		logic       taken;
		logic [1:0] taken_index;
		logic [1:0] first_long_index;
		logic [1:0] press_kind;
	} res_item_t;

endpackage

FILE: hdl/button_debounce_long_press.sv
// Button debouncer with one-shot press events and long-press detection.
// Request channel (req_valid/req_ready/req_data): a tick carries the raw
// pin levels, a take-one request clears the press event of button_index,
// a take-first request clears the lowest pending press event.
// Result channel (res_valid/res_ready/res_data): one item per request with
// the pending, long-press and held masks after the request has acted, the
// consumed index, the first long-pressed button from index 1 and a summary.
// Button state and the result register load at the edge that accepts the
// request. Throughput is one item per cycle while the receiver keeps up; the
// per-button debounce and counter logic is parallel and needs one pass.
// When the receiver stalls, the result register holds and req_ready drops
// until the result is taken; a result taken in the same cycle frees the slot.
// At reset the sample history and stable levels go to the released level,
// the one-shots arm, the flags and counters clear, and no result is held.
// The APB port (pready always high) holds long_press_ticks at 0x0 and
// pressed_level at 0x4; write it only while no request is in flight.
module button_debounce_long_press import bdlp_pkg::*; #(
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_ready,
	input  req_item_t         req_data,
	output logic              res_valid,
	input  logic              res_ready,
	output res_item_t         res_data
);

	localparam logic [NUM_BUTTONS-1:0] ALL_ONES = {NUM_BUTTONS{1'b1}};
	localparam logic [NUM_BUTTONS-1:0] REL_RST  = {NUM_BUTTONS{~PRESSED_LEVEL_RST}};
	localparam logic [1:0]             NONE_IDX = 2'(NUM_BUTTONS);

	// Configuration registers
	logic [TICKS_W-1:0] long_ticks_q;
	logic               pressed_lvl_q;

	// Button state
	logic [NUM_BUTTONS-1:0] hist_q [3];
	logic [NUM_BUTTONS-1:0] stable_q;
	logic [NUM_BUTTONS-1:0] down_q;
	logic [NUM_BUTTONS-1:0] armed_q;
	logic [NUM_BUTTONS-1:0] long_q;
	logic [TICKS_W-1:0]     cnt_q [NUM_BUTTONS];

	logic [NUM_BUTTONS-1:0] hist_d [3];
	logic [NUM_BUTTONS-1:0] stable_d;
	logic [NUM_BUTTONS-1:0] down_d;
	logic [NUM_BUTTONS-1:0] armed_d;
	logic [NUM_BUTTONS-1:0] long_d;
	logic [TICKS_W-1:0]     cnt_d [NUM_BUTTONS];

	logic [NUM_BUTTONS-1:0] pins;
	logic [NUM_BUTTONS-1:0] agree;
	logic [NUM_BUTTONS-1:0] pend_q;
	logic [NUM_BUTTONS-1:0] pend_d;
	logic [NUM_BUTTONS-1:0] sel_oh;
	logic [NUM_BUTTONS-1:0] first_oh;
	logic                   taken_d;
	logic [1:0]             taken_ix_d;
	logic [1:0]             first_pend_ix;
	logic [1:0]             first_long_d;
	logic [1:0]             kind_d;
	logic                   req_acc;
	logic                   cfg_wr;
	logic                   res_valid_q;
	res_item_t              res_q;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign req_ready = !res_valid_q || res_ready;
	assign req_acc   = req_valid && req_ready;
	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	// Read back the addressed register
	always_comb begin
		case (paddr[2])
			REG_LONG_TICKS:    prdata = DATA_W'(long_ticks_q);
			REG_PRESSED_LEVEL: prdata = DATA_W'(pressed_lvl_q);
			default:           prdata = '0;
		endcase
	end

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_ticks_q  <= LONG_TICKS_RST;
			pressed_lvl_q <= PRESSED_LEVEL_RST;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_LONG_TICKS:    long_ticks_q  <= pwdata[TICKS_W-1:0];
				REG_PRESSED_LEVEL: pressed_lvl_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	assign pins     = NUM_BUTTONS'(req_data.pin_levels);
	assign pend_q   = down_q & armed_q;
	assign sel_oh   = NUM_BUTTONS'(1) << req_data.button_index;
	assign first_oh = pend_q & (~pend_q + NUM_BUTTONS'(1));
	assign agree    = ~(hist_q[2] ^ hist_q[1]) & ~(hist_q[2] ^ pins);

	// Locate the lowest pending press
	always_comb begin
		first_pend_ix = NONE_IDX;
		for (int i = NUM_BUTTONS - 1; i >= 0; i--) begin
			if (pend_q[i]) begin
				first_pend_ix = 2'(i);
			end
		end
	end

	// Advance debounce, hold counters and one-shots for the accepted item
	always_comb begin
		logic [TICKS_W-1:0] dec;
		hist_d     = hist_q;
		stable_d   = stable_q;
		down_d     = down_q;
		armed_d    = armed_q;
		long_d     = long_q;
		cnt_d      = cnt_q;
		taken_d    = 1'b0;
		taken_ix_d = NONE_IDX;
		dec        = '0;
		case (req_data.req_type)
			REQ_TICK: begin
				hist_d[0] = hist_q[1];
				hist_d[1] = hist_q[2];
				hist_d[2] = pins;
				for (int i = 0; i < NUM_BUTTONS; i++) begin
					dec = (cnt_q[i] != '0) ? cnt_q[i] - TICKS_W'(1) : '0;
					if (agree[i]) begin
						if (pins[i] != stable_q[i]) begin
							stable_d[i] = pins[i];
							if (pins[i] == pressed_lvl_q) begin
								down_d[i] = 1'b1;
								cnt_d[i]  = long_ticks_q;
							end else begin
								down_d[i]  = 1'b0;
								long_d[i]  = 1'b0;
								armed_d[i] = 1'b1;
							end
						end else if (stable_q[i] == pressed_lvl_q) begin
							cnt_d[i] = dec;
							if (dec == '0) begin
								long_d[i] = 1'b1;
							end
						end
					end
				end
			end
			REQ_TAKE_ONE: begin
				// one-hot select is empty for an index beyond the buttons
				if ((pend_q & sel_oh) != '0) begin
					armed_d    = armed_q & ~sel_oh;
					taken_d    = 1'b1;
					taken_ix_d = req_data.button_index;
				end
			end
			REQ_TAKE_FIRST: begin
				if (pend_q != '0) begin
					armed_d    = armed_q & ~first_oh;
					taken_d    = 1'b1;
					taken_ix_d = first_pend_ix;
				end
			end
			default: ;
		endcase
	end

	assign pend_d = down_d & armed_d;

	// Build the status summary; button 0 is left out of the long-press index
	always_comb begin
		first_long_d = NONE_IDX;
		for (int i = NUM_BUTTONS - 1; i >= 1; i--) begin
			if (long_d[i]) begin
				first_long_d = 2'(i);
			end
		end
		if (pend_d != '0) begin
			kind_d = KIND_PENDING;
		end else if (long_d != '0) begin
			kind_d = KIND_LONG;
		end else begin
			kind_d = KIND_NONE;
		end
	end

	// Hold button state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_q[0] <= REL_RST;
			hist_q[1] <= REL_RST;
			hist_q[2] <= REL_RST;
			stable_q  <= REL_RST;
			down_q    <= '0;
			armed_q   <= ALL_ONES;
			long_q    <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				cnt_q[i] <= '0;
			end
		end else if (req_acc) begin
			hist_q   <= hist_d;
			stable_q <= stable_d;
			down_q   <= down_d;
			armed_q  <= armed_d;
			long_q   <= long_d;
			cnt_q    <= cnt_d;
		end
	end

	// Result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (req_acc) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			res_q.press_pending_mask <= 3'(pend_d);
			res_q.long_press_mask    <= 3'(long_d);
			res_q.held_mask          <= 3'(down_d);
			res_q.taken              <= taken_d;
			res_q.taken_index        <= taken_ix_d;
			res_q.first_long_index   <= first_long_d;
			res_q.press_kind         <= kind_d;
		end
	end

	// A pending press is always a held button
	a_pend_held: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> ((res_data.press_pending_mask & ~res_data.held_mask) == 3'd0))
		else $error("pending press on a released button");

	// No consume reports the none index
	a_none_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_data.taken) |-> (res_data.taken_index == NONE_IDX))
		else $error("taken index set without a consume");

	// Every accepted item shows up as a result in the next cycle
	a_acc_res: assert property (@(posedge clk) disable iff (!arst_n)
		req_acc |=> res_valid)
		else $error("accepted item produced no result");

	// A tick never consumes a press
	a_tick_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req_data.req_type == REQ_TICK)) |=> !res_data.taken)
		else $error("tick reported a consumed press");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb import bdlp_pkg::*; ();

	localparam int BUTTONS = NUM_BUTTONS_DEF;
	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_ITEMS = 230;
	localparam int PHASES = 8;
	localparam logic [15:0] PHASE_TICKS [PHASES] =
		'{16'd5, 16'd65535, 16'd2, 16'd20, 16'd1, 16'd0, 16'd9, 16'd40};
	localparam logic PHASE_LEVEL [PHASES] = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0};

	// Track debounce, one-shot and long-press state; hold the expected status items
	class press_status_tracker;
		logic [15:0] long_ticks;
		logic        press_level;
		logic [2:0]  hist [3];
		logic [2:0]  stable_lvl;
		logic [2:0]  down;
		logic [2:0]  armed;
		logic [2:0]  long_flag;
		logic [15:0] hold_cnt [BUTTONS];
		res_item_t   expected_status [$];
		int          errors;

		function void reset_state();
			logic [2:0] rel;
			long_ticks = LONG_TICKS_RST;
			press_level = PRESSED_LEVEL_RST;
			rel = press_level ? 3'b000 : 3'b111;
			for (int i = 0; i < 3; i++) hist[i] = rel;
			stable_lvl = rel;
			down = '0;
			armed = '1;
			long_flag = '0;
			for (int i = 0; i < BUTTONS; i++) hold_cnt[i] = '0;
			errors = 0;
			expected_status.delete();
		endfunction

		// Shift in one sample set and act on buttons whose last three samples agree
		function void sample_pins(logic [2:0] pins);
			logic [2:0] agree;
			hist[0] = hist[1];
			hist[1] = hist[2];
			hist[2] = pins;
			agree = ~(hist[0] ^ hist[1]) & ~(hist[1] ^ hist[2]);
			for (int i = 0; i < BUTTONS; i++) begin
				if (!agree[i]) continue;
				if (hist[2][i] != stable_lvl[i]) begin
					stable_lvl[i] = hist[2][i];
					if (hist[2][i] == press_level) begin
						down[i] = 1'b1;
						hold_cnt[i] = long_ticks;
					end else begin
						down[i] = 1'b0;
						long_flag[i] = 1'b0;
						armed[i] = 1'b1;
					end
				end else if (stable_lvl[i] == press_level) begin
					// count down, saturating at zero
					if (hold_cnt[i] != 0) hold_cnt[i] = hold_cnt[i] - 16'd1;
					if (hold_cnt[i] == 0) long_flag[i] = 1'b1;
				end
			end
		endfunction

		function void note_request(req_item_t r);
			res_item_t  st;
			logic [2:0] pending;
			st = '0;
			st.taken_index = 2'(BUTTONS);
			st.first_long_index = 2'(BUTTONS);
			pending = down & armed;
			case (r.req_type)
				REQ_TICK: sample_pins(r.pin_levels);
				REQ_TAKE_ONE: begin
					if (int'(r.button_index) < BUTTONS && pending[r.button_index]) begin
						armed[r.button_index] = 1'b0;
						st.taken = 1'b1;
						st.taken_index = r.button_index;
					end
				end
				REQ_TAKE_FIRST: begin
					for (int i = 0; i < BUTTONS; i++) begin
						if (pending[i] && !st.taken) begin
							armed[i] = 1'b0;
							st.taken = 1'b1;
							st.taken_index = 2'(i);
						end
					end
				end
				default: ;
			endcase
			pending = down & armed;
			// button 0 is never reported as first long press
			for (int i = BUTTONS - 1; i >= 1; i--)
				if (long_flag[i]) st.first_long_index = 2'(i);
			st.press_pending_mask = pending;
			st.long_press_mask = long_flag;
			st.held_mask = down;
			if (pending != 0) st.press_kind = KIND_PENDING;
			else if (long_flag != 0) st.press_kind = KIND_LONG;
			else st.press_kind = KIND_NONE;
			expected_status.push_back(st);
		endfunction

		function void compare_field(string field, logic [3:0] want, logic [3:0] got);
			if (want !== got) begin
				errors++;
				$display("%0t: %s expected %0h got %0h", $time, field, want, got);
			end
		endfunction

		function void check_status(res_item_t got);
			res_item_t want;
			if (expected_status.size() == 0) begin
				errors++;
				$display("%0t: status item with none expected, got %h", $time, got);
				return;
			end
			want = expected_status.pop_front();
			compare_field("press_pending_mask", 4'(want.press_pending_mask),
				4'(got.press_pending_mask));
			compare_field("long_press_mask", 4'(want.long_press_mask),
				4'(got.long_press_mask));
			compare_field("held_mask", 4'(want.held_mask), 4'(got.held_mask));
			compare_field("taken", 4'(want.taken), 4'(got.taken));
			compare_field("taken_index", 4'(want.taken_index), 4'(got.taken_index));
			compare_field("first_long_index", 4'(want.first_long_index),
				4'(got.first_long_index));
			compare_field("press_kind", 4'(want.press_kind), 4'(got.press_kind));
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              req_valid;
	logic              req_ready;
	req_item_t         req_data;
	logic              res_valid;
	logic              res_ready;
	res_item_t         res_data;

	press_status_tracker tracker;
	bit          send_steady;
	bit          take_steady;
	int          hold_off_cycles;
	int unsigned cycles = 0;

	button_debounce_long_press dut (.*);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// End the run if it hangs
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL button_debounce_long_press");
			$finish;
		end
	end

	// Offer one request item after a random gap and wait for its acceptance
	task automatic send_req(logic [1:0] kind, logic [2:0] pins, logic [1:0] idx);
		req_item_t item;
		int        gap;
		item.req_type = kind;
		item.pin_levels = pins;
		item.button_index = idx;
		gap = send_steady ? 0 : $urandom_range(0, 15);
		repeat (gap) @(negedge clk) req_valid <= 1'b0;
		@(negedge clk);
		req_valid <= 1'b1;
		req_data <= item;
		do @(posedge clk); while (!req_ready);
		tracker.note_request(item);
	endtask

	// Stop offering and wait for every expected status item
	task automatic drain();
		@(negedge clk) req_valid <= 1'b0;
		while (tracker.expected_status.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apb_write(logic reg_sel, logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= value;
		@(negedge clk) penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic configure(logic [15:0] ticks, logic level);
		drain();
		apb_write(REG_LONG_TICKS, DATA_W'(ticks));
		tracker.long_ticks = ticks;
		apb_write(REG_PRESSED_LEVEL, DATA_W'(level));
		tracker.press_level = level;
	endtask

	// Mostly held pin patterns with occasional glitches, mixed with consume requests
	task automatic random_phase(int count);
		logic [2:0] pattern;
		logic [2:0] pins;
		int         run_left;
		int         roll;
		pattern = 3'($urandom_range(0, 7));
		run_left = 0;
		for (int n = 0; n < count; n++) begin
			if (n % 64 == 0) send_steady = ($urandom_range(0, 3) == 0);
			roll = $urandom_range(0, 99);
			if (roll < 70) begin
				if (run_left == 0) begin
					pattern = 3'($urandom_range(0, 7));
					run_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 60)
					                                       : $urandom_range(1, 8);
				end
				run_left--;
				pins = pattern;
				if ($urandom_range(0, 9) == 0) pins = pattern ^ (3'b001 << $urandom_range(0, 2));
				send_req(REQ_TICK, pins, 2'($urandom));
			end else if (roll < 85) begin
				send_req(REQ_TAKE_ONE, 3'($urandom), 2'($urandom_range(0, 3)));
			end else if (roll < 97) begin
				send_req(REQ_TAKE_FIRST, 3'($urandom), 2'($urandom));
			end else begin
				send_req(REQ_UNUSED, 3'($urandom), 2'($urandom));
			end
		end
	endtask

	// Accept status items after random stalls; honor a long hold-off when asked
	initial begin : result_sink
		int stall;
		int seen;
		res_ready = 1'b0;
		take_steady = 1'b0;
		seen = 0;
		forever begin
			if (hold_off_cycles > 0) begin
				repeat (hold_off_cycles) @(negedge clk) res_ready <= 1'b0;
				hold_off_cycles = 0;
			end else begin
				stall = take_steady ? 0 : $urandom_range(0, 15);
				repeat (stall) @(negedge clk) res_ready <= 1'b0;
			end
			@(negedge clk) res_ready <= 1'b1;
			do @(posedge clk); while (!res_valid);
			tracker.check_status(res_data);
			seen++;
			if (seen % 50 == 0) take_steady = ($urandom_range(0, 3) == 0);
		end
	end

	initial begin
		tracker = new();
		tracker.reset_state();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		send_steady = 1'b0;
		hold_off_cycles = 0;
		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Active low, one-tick duration
		configure(16'd1, 1'b0);
		send_req(REQ_UNUSED, 3'b101, 2'd2);
		send_req(REQ_TAKE_ONE, 3'b000, 2'd3);
		send_req(REQ_TAKE_FIRST, 3'b111, 2'd0);
		// press all three buttons
		repeat (3) send_req(REQ_TICK, 3'b000, 2'd0);
		send_req(REQ_TAKE_ONE, 3'b111, 2'd1);
		send_req(REQ_TAKE_ONE, 3'b111, 2'd3);
		send_req(REQ_TAKE_FIRST, 3'b010, 2'd1);
		// counter reaches zero and sets the long-press flags
		send_req(REQ_TICK, 3'b000, 2'd3);
		send_req(REQ_TAKE_ONE, 3'b000, 2'd2);
		send_req(REQ_TICK, 3'b000, 2'd0);
		// release button 1, then all
		repeat (3) send_req(REQ_TICK, 3'b010, 2'd0);
		repeat (3) send_req(REQ_TICK, 3'b111, 2'd1);

		// Flip polarity with history untouched, then zero duration
		configure(16'd0, 1'b1);
		send_req(REQ_TICK, 3'b111, 2'd0);
		repeat (3) send_req(REQ_TICK, 3'b000, 2'd0);
		repeat (4) send_req(REQ_TICK, 3'b111, 2'd0);

		for (int p = 0; p < PHASES; p++) begin
			configure(PHASE_TICKS[p], PHASE_LEVEL[p]);
			if (p == 3) begin
				// hold the receiver off while requests keep coming
				hold_off_cycles = 80;
				send_steady = 1'b1;
				repeat (24) send_req(REQ_TICK, 3'($urandom), 2'($urandom));
				drain();
			end
			random_phase(PHASE_ITEMS);
		end

		drain();
		repeat (8) @(posedge clk);
		if (tracker.errors == 0 && tracker.expected_status.size() == 0) begin
			$display("PASS button_debounce_long_press");
		end else begin
			$display("FAIL button_debounce_long_press");
		end
		$finish;
	end

endmodule
